### src/pbwa_pkg.sv
`default_nettype none
package pbwa_pkg;

    // operation codes carried in the input tuser
    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_ALIGN = 2'd2;

    // window codes
    localparam logic [1:0] WIN_MEM  = 2'd0;
    localparam logic [1:0] WIN_PREF = 2'd1;
    localparam logic [1:0] WIN_IO   = 2'd2;

    // register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREF_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREF_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IO_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IO_LENGTH  = 3'd5;

    localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
    localparam logic [31:0] LOW_FLOOR    = 32'h0000_1000;
    localparam logic [31:0] IO_SIZE_MASK = 32'h0000_ffff;
    localparam logic [31:0] MEG_ALIGN    = 32'h0010_0000;
    localparam logic [31:0] IO_ALIGN     = 32'h0000_1000;

    // decoded BAR probe
    typedef struct packed {
        logic        implemented;
        logic        is_io;
        logic        is_wide;
        logic [1:0]  window_used;
        logic [31:0] decoded_size;
    } probe_dec_t;

    // one result item
    typedef struct packed {
        logic [31:0] assigned_addr;
        logic        granted;
        probe_dec_t  dec;
        logic [31:0] mem_pointer;
        logic [31:0] pref_pointer;
        logic [31:0] io_pointer;
    } result_t;

    // round a pointer up to a power-of-two size, 32-bit wrapping
    function automatic logic [31:0] align_up(input logic [31:0] p, input logic [31:0] size);
        align_up = ((p - 32'd1) | (size - 32'd1)) + 32'd1;
    endfunction

endpackage
`default_nettype wire

### src/pbwa_probe_dec.sv
`default_nettype none
module pbwa_probe_dec
    import pbwa_pkg::*;
(
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] probe_word,
    output probe_dec_t       dec
);

    logic [31:0] io_size;
    logic [31:0] mem_size;
    logic        wide;

    // sizes from the probe readback
    assign io_size  = ((~{probe_word[31:2], 2'b00}) & IO_SIZE_MASK) + 32'd1;
    assign mem_size = (~{probe_word[31:4], 4'b0000}) + 32'd1;
    assign wide     = (probe_word[2:1] == 2'b10);

    always_comb
    begin
        dec = '0;
        if (mode == MODE_ALLOC && probe_word != 32'd0)
        begin
            dec.implemented = 1'b1;
            if (probe_word[0])
            begin
                dec.is_io        = 1'b1;
                dec.decoded_size = io_size;
                dec.window_used  = WIN_IO;
            end
            else
            begin
                dec.is_wide      = wide;
                dec.decoded_size = mem_size;
                dec.window_used  = (wide && probe_word[3]) ? WIN_PREF : WIN_MEM;
            end
        end
    end

endmodule
`default_nettype wire

### src/pbwa_windows.sv
`default_nettype none
module pbwa_windows
    import pbwa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 step_en,
    input  wire logic [1:0]           mode,
    input  wire probe_dec_t           dec,
    output result_t                   res
);

    logic [31:0] mem_start_reg, mem_length_reg, pref_start_reg, pref_length_reg;
    logic [31:0] io_start_reg, io_length_reg;
    logic [31:0] mem_next_reg, pref_next_reg, io_next_reg;
    logic [31:0] mem_next_next, pref_next_next, io_next_next;

    logic        mem_cfgd, pref_cfgd, io_cfgd;
    logic [31:0] sel_next, sel_start, sel_len, cand, span;
    logic        fit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_start_reg   <= '0;
            mem_length_reg  <= '0;
            pref_start_reg  <= '0;
            pref_length_reg <= '0;
            io_start_reg    <= '0;
            io_length_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MEM_START:  mem_start_reg   <= cfg_data;
                REG_MEM_LENGTH: mem_length_reg  <= cfg_data;
                REG_PREF_START: pref_start_reg  <= cfg_data;
                REG_PREF_LEN:   pref_length_reg <= cfg_data;
                REG_IO_START:   io_start_reg    <= cfg_data;
                REG_IO_LENGTH:  io_length_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign mem_cfgd  = (mem_start_reg != '0) || (mem_length_reg != '0);
    assign pref_cfgd = (pref_start_reg != '0) || (pref_length_reg != '0);
    assign io_cfgd   = (io_start_reg != '0) || (io_length_reg != '0);

    // window selection for an allocation
    always_comb
    begin
        case (dec.window_used)
            WIN_IO:
            begin
                sel_next  = io_next_reg;
                sel_start = io_start_reg;
                sel_len   = io_length_reg;
            end
            WIN_PREF:
            begin
                sel_next  = pref_next_reg;
                sel_start = pref_start_reg;
                sel_len   = pref_length_reg;
            end
            default:
            begin
                sel_next  = mem_next_reg;
                sel_start = mem_start_reg;
                sel_len   = mem_length_reg;
            end
        endcase
    end

    // aligned candidate and limit check; size - start runs beside the align
    assign cand = align_up(sel_next, dec.decoded_size);
    assign span = cand + (dec.decoded_size - sel_start);
    assign fit  = dec.implemented && !(span > sel_len);

    // pointer updates
    always_comb
    begin
        mem_next_next  = mem_next_reg;
        pref_next_next = pref_next_reg;
        io_next_next   = io_next_reg;
        case (mode)
            MODE_INIT:
            begin
                if (mem_cfgd)
                    mem_next_next = (mem_start_reg != '0) ? mem_start_reg : LOW_FLOOR;
                if (pref_cfgd)
                    pref_next_next = (pref_start_reg != '0) ? pref_start_reg : LOW_FLOOR;
                if (io_cfgd)
                    io_next_next = (io_start_reg != '0) ? io_start_reg : LOW_FLOOR;
            end
            MODE_ALIGN:
            begin
                if (mem_cfgd)
                    mem_next_next = align_up(mem_next_reg, MEG_ALIGN);
                if (pref_cfgd)
                    pref_next_next = align_up(pref_next_reg, MEG_ALIGN);
                if (io_cfgd)
                    io_next_next = align_up(io_next_reg, IO_ALIGN);
            end
            MODE_ALLOC:
            begin
                if (fit)
                begin
                    case (dec.window_used)
                        WIN_IO:   io_next_next   = cand + dec.decoded_size;
                        WIN_PREF: pref_next_next = cand + dec.decoded_size;
                        default:  mem_next_next  = cand + dec.decoded_size;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_next_reg  <= '0;
            pref_next_reg <= '0;
            io_next_reg   <= '0;
        end
        else if (step_en)
        begin
            mem_next_reg  <= mem_next_next;
            pref_next_reg <= pref_next_next;
            io_next_reg   <= io_next_next;
        end
    end

    // result as seen after this step
    always_comb
    begin
        res               = '0;
        res.dec           = dec;
        res.granted       = fit;
        res.assigned_addr = fit ? cand : ALL_ONES;
        res.mem_pointer   = mem_next_next;
        res.pref_pointer  = pref_next_next;
        res.io_pointer    = io_next_next;
    end

endmodule
`default_nettype wire

### src/pci_bar_window_allocator_unit.sv
// Channel   Dir   Handshake         Payload
// s_axis    in    tvalid/tready     tdata: probe_word; tuser: mode
// m_axis    out   tvalid/tready     tdata: addr, size, pointers; tuser: flags, window
// cfg       in    cfg_valid/ready   cfg_index, cfg_data
//
// One item per cycle sustained while m_axis accepts results: input register, one pass of
// decode and window arithmetic, result register, between s_axis and m_axis.
// The pointer registers update as the item moves into the result register,
// so the next item sees them at once. rst_n clears both stages, the
// window registers and the pointers. A stalled m_axis holds the result; one
// more item waits in the input register. cfg is always ready.
`default_nettype none
module pci_bar_window_allocator_unit
    import pbwa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,   // [31:0] probe_word
    input  wire logic [1:0]           s_axis_tuser,   // [1:0] mode

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [31:0] assigned_addr, [63:32] decoded_size, [95:64] mem_pointer,
    // [127:96] pref_pointer, [159:128] io_pointer
    output logic [159:0]              m_axis_tdata,
    // [0] granted, [1] implemented, [2] is_io, [3] is_wide, [5:4] window_used
    output logic [5:0]                m_axis_tuser,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    logic        stage_v_reg;
    logic [1:0]  stage_mode_reg;
    logic [31:0] stage_probe_reg;
    logic        out_v_reg;
    result_t     out_reg;

    logic        advance;
    logic        take_in;
    probe_dec_t  dec;
    result_t     res;

    assign cfg_ready     = 1'b1;
    assign advance       = stage_v_reg && (!out_v_reg || m_axis_tready);
    assign s_axis_tready = !stage_v_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_v_reg <= 1'b0;
        else if (take_in)
            stage_v_reg <= 1'b1;
        else if (advance)
            stage_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stage_mode_reg  <= s_axis_tuser;
            stage_probe_reg <= s_axis_tdata;
        end
    end

    pbwa_probe_dec u_dec
    (
        .mode       (stage_mode_reg),
        .probe_word (stage_probe_reg),
        .dec        (dec)
    );

    pbwa_windows u_win
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .mode      (stage_mode_reg),
        .dec       (dec),
        .res       (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= 1'b1;
        else if (m_axis_tready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {out_reg.io_pointer, out_reg.pref_pointer, out_reg.mem_pointer,
                            out_reg.dec.decoded_size, out_reg.assigned_addr};
    assign m_axis_tuser  = {out_reg.dec.window_used, out_reg.dec.is_wide, out_reg.dec.is_io,
                            out_reg.dec.implemented, out_reg.granted};

    // a grant only follows a real BAR
    a_grant_impl: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.granted) |-> out_reg.dec.implemented)
        else $error("grant without implemented BAR");

    // I/O BARs always land in the I/O window
    a_io_win: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.dec.is_io) |-> (out_reg.dec.window_used == WIN_IO))
        else $error("I/O BAR outside I/O window");

    // empty result register never blocks input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // an item held behind a stalled result keeps its contents
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_v_reg && out_v_reg && !m_axis_tready) |=>
            ($stable(stage_mode_reg) && $stable(stage_probe_reg)))
        else $error("held input item changed");

endmodule
`default_nettype wire

### bench/bar_alloc_checker.sv
module bar_alloc_checker
    import pbwa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] probe_word
    input  logic [1:0]           s_axis_tuser,   // [1:0] mode

    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] assigned_addr, [63:32] decoded_size, [95:64] mem_pointer,
    // [127:96] pref_pointer, [159:128] io_pointer
    input  logic [159:0]         m_axis_tdata,
    // [0] granted, [1] implemented, [2] is_io, [3] is_wide, [5:4] window_used
    input  logic [5:0]           m_axis_tuser,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // memory BAR type field, bits 2:1 of the probe
    localparam logic [1:0] BAR_TYPE_64 = 2'b10;

    // window registers and next-free pointers, indexed by window code
    logic [31:0] win_base [3];
    logic [31:0] win_len  [3];
    logic [31:0] win_ptr  [3];

    result_t     pending_results [$];
    int          err_count = 0;

    assign mismatches = err_count;

    function automatic logic [31:0] round_up_pow2(input logic [31:0] ptr,
                                                  input logic [31:0] gran);
        return ((ptr - 32'd1) | (gran - 32'd1)) + 32'd1;
    endfunction

    // expected result of one input transaction; updates the pointers
    function automatic result_t predict_bar_step(input logic [1:0] mode,
                                                 input logic [31:0] probe);
        result_t     res;
        logic [1:0]  win;
        logic [31:0] size;
        logic [31:0] base;
        logic [31:0] span;
        res = '0;
        res.assigned_addr = ALL_ONES;
        case (mode)
            MODE_INIT:
            begin
                // a window counts as configured when start or length is nonzero
                for (int w = 0; w < 3; w++)
                begin
                    if (win_base[w] != 32'd0 || win_len[w] != 32'd0)
                        win_ptr[w] = (win_base[w] != 32'd0) ? win_base[w] : LOW_FLOOR;
                end
            end
            MODE_ALIGN:
            begin
                for (int w = 0; w < 3; w++)
                begin
                    if (win_base[w] != 32'd0 || win_len[w] != 32'd0)
                        win_ptr[w] = round_up_pow2(win_ptr[w],
                                                   (w == WIN_IO) ? IO_ALIGN : MEG_ALIGN);
                end
            end
            MODE_ALLOC:
            begin
                if (probe != 32'd0)
                begin
                    res.dec.implemented = 1'b1;
                    if (probe[0])
                    begin
                        res.dec.is_io = 1'b1;
                        size = (~(probe & ~32'd3) & IO_SIZE_MASK) + 32'd1;
                        win  = WIN_IO;
                    end
                    else
                    begin
                        res.dec.is_wide = (probe[2:1] == BAR_TYPE_64);
                        size = ~(probe & ~32'hf) + 32'd1;
                        // only 64-bit prefetchable BARs go to the prefetch window
                        win  = (res.dec.is_wide && probe[3]) ? WIN_PREF : WIN_MEM;
                    end
                    res.dec.window_used  = win;
                    res.dec.decoded_size = size;
                    base = round_up_pow2(win_ptr[win], size);
                    span = base - win_base[win] + size;
                    if (span <= win_len[win])
                    begin
                        win_ptr[win]      = base + size;
                        res.assigned_addr = base;
                        res.granted       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.mem_pointer  = win_ptr[WIN_MEM];
        res.pref_pointer = win_ptr[WIN_PREF];
        res.io_pointer   = win_ptr[WIN_IO];
        return res;
    endfunction

    task automatic check_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, actual 0x%08h", field_name, want, got);
            err_count++;
        end
    endtask

    // watch all three channels; results are compared before new inputs are queued
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int w = 0; w < 3; w++)
            begin
                win_base[w] = '0;
                win_len[w]  = '0;
                win_ptr[w]  = '0;
            end
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no expected result waiting");
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("assigned_addr", want.assigned_addr, m_axis_tdata[31:0]);
                    check_field("decoded_size", want.dec.decoded_size, m_axis_tdata[63:32]);
                    check_field("mem_pointer", want.mem_pointer, m_axis_tdata[95:64]);
                    check_field("pref_pointer", want.pref_pointer, m_axis_tdata[127:96]);
                    check_field("io_pointer", want.io_pointer, m_axis_tdata[159:128]);
                    check_field("granted", 32'(want.granted), 32'(m_axis_tuser[0]));
                    check_field("implemented", 32'(want.dec.implemented),
                                32'(m_axis_tuser[1]));
                    check_field("is_io", 32'(want.dec.is_io), 32'(m_axis_tuser[2]));
                    check_field("is_wide", 32'(want.dec.is_wide), 32'(m_axis_tuser[3]));
                    check_field("window_used", 32'(want.dec.window_used),
                                32'(m_axis_tuser[5:4]));
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MEM_START:  win_base[WIN_MEM]  = cfg_data;
                    REG_MEM_LENGTH: win_len[WIN_MEM]   = cfg_data;
                    REG_PREF_START: win_base[WIN_PREF] = cfg_data;
                    REG_PREF_LEN:   win_len[WIN_PREF]  = cfg_data;
                    REG_IO_START:   win_base[WIN_IO]   = cfg_data;
                    REG_IO_LENGTH:  win_len[WIN_IO]    = cfg_data;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(predict_bar_step(s_axis_tuser, s_axis_tdata));

            outstanding <= pending_results.size();
        end
    end

endmodule

### bench/pci_bar_window_allocator_unit_test.sv
module pci_bar_window_allocator_unit_test;
    import pbwa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // unused mode code, must leave all state alone
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;   // [31:0] probe_word
    logic [1:0]           s_axis_tuser  = '0;   // [1:0] mode

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [31:0] assigned_addr, [63:32] decoded_size, [95:64] mem_pointer,
    // [127:96] pref_pointer, [159:128] io_pointer
    logic [159:0]         m_axis_tdata;
    // [0] granted, [1] implemented, [2] is_io, [3] is_wide, [5:4] window_used
    logic [5:0]           m_axis_tuser;

    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [31:0]          cfg_data      = '0;

    int                   fail_count;
    int                   outstanding;
    int                   burst_left    = 0;
    int                   rx_cycle      = 0;
    int                   rx_style      = 0;
    int                   cycle_count   = 0;

    pci_bar_window_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bar_alloc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side: style changes now and then; always ready, random, or sparse
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0)
            rx_style <= $urandom_range(0, 2);
        case (rx_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= (rx_cycle % 8 == 5);
        endcase
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // one input transaction; valid stays high within a burst
    task automatic send_probe(input logic [1:0] mode, input logic [31:0] probe);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= probe;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_windows(input logic [31:0] mem_base, input logic [31:0] mem_len,
                                   input logic [31:0] pref_base, input logic [31:0] pref_len,
                                   input logic [31:0] io_base, input logic [31:0] io_len);
        write_reg(REG_MEM_START, mem_base);
        write_reg(REG_MEM_LENGTH, mem_len);
        write_reg(REG_PREF_START, pref_base);
        write_reg(REG_PREF_LEN, pref_len);
        write_reg(REG_IO_START, io_base);
        write_reg(REG_IO_LENGTH, io_len);
        cfg_valid <= 1'b0;
    endtask

    // bridge-like windows: MB-aligned memory, small I/O, now and then odd values
    task automatic program_random_windows();
        logic [31:0] mem_base;
        logic [31:0] mem_len;
        logic [31:0] pref_base;
        logic [31:0] pref_len;
        logic [31:0] io_base;
        logic [31:0] io_len;
        mem_base  = ($urandom_range(0, 5) == 0) ? 32'd0 : ($urandom & 32'hfff0_0000);
        mem_len   = ($urandom_range(0, 7) == 0) ? $urandom
                                                : (32'd1 << $urandom_range(16, 30));
        pref_base = ($urandom_range(0, 5) == 0) ? 32'd0 : ($urandom & 32'hfff0_0000);
        pref_len  = ($urandom_range(0, 7) == 0) ? $urandom
                                                : (32'd1 << $urandom_range(16, 30));
        io_base   = ($urandom_range(0, 3) == 0) ? 32'd0 : ($urandom & 32'h0000_f000);
        io_len    = ($urandom_range(0, 7) == 0) ? $urandom
                                                : (32'd1 << $urandom_range(8, 16));
        program_windows(mem_base, mem_len, pref_base, pref_len, io_base, io_len);
    endtask

    // mostly well-formed BAR probes, some noise and other modes
    task automatic issue_random_item();
        int          pick;
        int          k;
        logic [31:0] probe;
        pick = $urandom_range(0, 99);
        if (pick < 68)
        begin
            // memory BAR, sizes mostly small so a window takes many of them
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 31) : $urandom_range(4, 20);
            probe    = ~((32'd1 << k) - 32'd1) & 32'hffff_fff0;
            probe[3] = 1'($urandom_range(0, 1));      // prefetchable
            probe[2] = ($urandom_range(0, 2) != 0);   // 64-bit
            probe[1] = ($urandom_range(0, 15) == 0);  // reserved type
            send_probe(MODE_ALLOC, probe);
        end
        else if (pick < 82)
        begin
            // I/O BAR, upper half sometimes not implemented
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 16) : $urandom_range(2, 8);
            probe = (~((32'd1 << k) - 32'd1) & 32'hffff_fffc) | 32'd1;
            if ($urandom_range(0, 1) == 0)
                probe[31:16] = '0;
            probe[1] = ($urandom_range(0, 7) == 0);
            send_probe(MODE_ALLOC, probe);
        end
        else if (pick < 90)
            send_probe(MODE_ALLOC, $urandom);
        else if (pick < 94)
            send_probe(MODE_ALIGN, $urandom);
        else if (pick < 97)
            send_probe(MODE_INIT, $urandom);
        else
            send_probe(MODE_RESERVED, $urandom);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: allocation with nothing configured
        send_probe(MODE_ALLOC, 32'hfff0_0000);
        wait_for_drain();
        program_windows(32'h8000_0000, 32'h1000_0000, 32'hc000_0000, 32'h1000_0000,
                        32'd0, 32'h0001_0000);
        send_probe(MODE_INIT, 32'd0);
        send_probe(MODE_ALLOC, 32'd0);            // unimplemented BAR
        send_probe(MODE_ALLOC, 32'hffff_ffff);    // smallest I/O BAR
        send_probe(MODE_ALLOC, 32'hffff_fffe);    // reserved memory type
        send_probe(MODE_ALLOC, 32'hfff0_000c);    // 64-bit prefetchable
        send_probe(MODE_ALLOC, 32'hfff0_0004);    // 64-bit, not prefetchable
        send_probe(MODE_ALLOC, 32'hfff0_0008);    // 32-bit prefetchable
        send_probe(MODE_ALLOC, 32'h0000_000c);    // zero decoded size
        send_probe(MODE_ALLOC, 32'h0000_0001);    // I/O, full 64K
        send_probe(MODE_ALLOC, 32'h0000_fff1);    // I/O, upper half zero
        send_probe(MODE_ALLOC, 32'h8000_0000);    // 2 GB, aligned address wraps to zero
        send_probe(MODE_ALLOC, 32'hf800_0000);    // first half of the memory window
        send_probe(MODE_ALLOC, 32'hf800_0000);    // fills the memory window
        send_probe(MODE_ALIGN, 32'd0);
        send_probe(MODE_RESERVED, 32'hffff_ffff);
        send_probe(MODE_ALLOC, 32'h0000_0010);    // near 4 GB size
        send_probe(MODE_INIT, 32'hffff_ffff);

        // random phases, the first three at extreme window settings
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_drain();
            case (phase)
                0:       program_windows('0, '0, '0, '0, '0, '0);
                1:       program_windows('1, '1, '1, '1, '1, '1);
                2:       program_windows(32'd0, 32'hffff_ffff, 32'd0, 32'd0,
                                         32'd0, 32'h0001_0000);
                default: program_random_windows();
            endcase
            send_probe(MODE_INIT, $urandom);
            repeat (ITEMS_PER_PHASE) issue_random_item();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
